// ----- rtl/sdspi_pkg.sv -----
//------------------------------------------------------------------------------
// sdspi_pkg
// Shared types and constants for the SPI-mode SD command engine.
//------------------------------------------------------------------------------
`default_nettype none

package sdspi_pkg;

	// Frame and gap lengths, in SPI bit-times
	localparam int GAP_CLOCKS = 8;
	localparam int FRAME_BITS = 48;
	localparam int CNT_W      = 6;   // holds FRAME_BITS and any GAP_CLOCKS up to 32

	// Item action codes
	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_START = 1'b1;

	// Response kinds
	localparam logic [1:0] KIND_R1  = 2'd0;
	localparam logic [1:0] KIND_R1B = 2'd1;
	localparam logic [1:0] KIND_R2  = 2'd2;

	// Frame constants
	localparam logic [1:0] CMD_PREFIX = 2'b01;   // start bit 0, transmission bit 1
	localparam logic [7:0] CRC_CMD0   = 8'h95;
	localparam logic [7:0] CRC_NONE   = 8'hFF;
	localparam logic [7:0] BYTE_IDLE  = 8'hFF;
	localparam logic [7:0] BYTE_ZERO  = 8'h00;
	localparam logic [7:0] R1_UPPER   = 8'hFF;

	// Input and output item widths
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_CMD  = 3'd1,
		PH_GAP1 = 3'd2,
		PH_R1   = 3'd3,
		PH_BUSY = 3'd4,
		PH_R2   = 3'd5,
		PH_GAP2 = 3'd6
	} phase_t;

	typedef struct packed {
		logic        action;
		logic [5:0]  cmd_index;
		logic [31:0] cmd_arg;
		logic [1:0]  resp_kind;
		logic        hold_select;
		logic        miso_bit;
	} item_t;

	typedef struct packed {
		logic        select_n;
		logic        mosi_bit;
		logic        clock_pulse;
		logic        busy_res;
		logic        done_res;
		logic [15:0] response;
		logic        start_refused;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/sd_spi_command_engine.sv -----
//------------------------------------------------------------------------------
// sd_spi_command_engine
// SPI-mode SD command engine: one SPI bit-time per input item, R1/R1b/R2.
//------------------------------------------------------------------------------
//  channel   direction  payload                                   handshake
//  s_*       in         tuser: action; tdata: command fields       tvalid/tready
//  m_*       out        tdata: line levels, status, response       tvalid/tready
//
// Each input item is processed at the accepting edge: the transaction state
// updates and the result lands in the output register, so one
// item per clock is sustained while the consumer keeps m_tready high.
// The output register is the only stage: s_tready is high when it is empty
// or being emptied in the same cycle, so a stalled result holds the input.
// Reset (arst_n low) returns to idle with chip select released.
//------------------------------------------------------------------------------
`default_nettype none

module sd_spi_command_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// s_tuser: [0] action
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [0:0]  s_tuser,
	// s_tdata: [5:0] cmd_index, [37:6] cmd_arg, [39:38] resp_kind,
	//          [40] hold_select, [41] miso_bit, [47:42] zero
	input  wire logic [sdspi_pkg::IN_DATA_W-1:0] s_tdata,
	// m_tdata: [0] select_n, [1] mosi_bit, [2] clock_pulse, [3] busy_res,
	//          [4] done_res, [20:5] response, [21] start_refused, [23:22] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [sdspi_pkg::OUT_DATA_W-1:0] m_tdata
);

	sdspi_pkg::item_t   item;
	sdspi_pkg::result_t res_d, res_q;
	logic               accept;
	logic               room;

	// unpack the input item
	assign item.action      = s_tuser[0];
	assign item.cmd_index   = s_tdata[5:0];
	assign item.cmd_arg     = s_tdata[37:6];
	assign item.resp_kind   = s_tdata[39:38];
	assign item.hold_select = s_tdata[40];
	assign item.miso_bit    = s_tdata[41];

	assign s_tready = room;
	assign accept   = s_tvalid && room;

	sdspi_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.item    (item),
		.res     (res_d)
	);

	sdspi_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.res_d  (res_d),
		.take   (m_tready),
		.room   (room),
		.valid  (m_tvalid),
		.res_q  (res_q)
	);

	// pack the result item, highest field first
	assign m_tdata = {2'b00, res_q.start_refused, res_q.response, res_q.done_res,
		res_q.busy_res, res_q.clock_pulse, res_q.mosi_bit, res_q.select_n};

endmodule

`default_nettype wire

// ----- rtl/sdspi_core.sv -----
//------------------------------------------------------------------------------
// sdspi_core
// Transaction state and per-item next-state logic of the command engine.
//------------------------------------------------------------------------------
`default_nettype none

module sdspi_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire sdspi_pkg::item_t  item,
	output sdspi_pkg::result_t     res
);

	sdspi_pkg::phase_t              phase_q, phase_d;
	logic [sdspi_pkg::CNT_W-1:0]    bit_count_q, bit_count_d, cnt_inc;
	logic [47:0]                    out_shift_q, out_shift_d;
	logic [15:0]                    in_shift_q, in_shift_d, in_next;
	logic [1:0]                     kind_q, kind_d;
	logic                           hold_q, hold_d;
	logic                           sel_q, sel_d;
	logic [15:0]                    resp_held_q, resp_held_d;
	logic                           do_release;
	logic [7:0]                     crc;

	always_comb begin
		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		out_shift_d = out_shift_q;
		in_shift_d  = in_shift_q;
		kind_d      = kind_q;
		hold_d      = hold_q;
		sel_d       = sel_q;
		resp_held_d = resp_held_q;
		do_release  = 1'b0;
		cnt_inc     = bit_count_q + sdspi_pkg::CNT_W'(1);
		in_next     = {in_shift_q[14:0], item.miso_bit};
		crc         = (item.cmd_index == 6'd0) ? sdspi_pkg::CRC_CMD0 : sdspi_pkg::CRC_NONE;

		res               = '0;
		res.select_n      = sel_q;
		res.mosi_bit      = 1'b1;

		if (item.action == sdspi_pkg::ACT_START) begin
			if (phase_q != sdspi_pkg::PH_IDLE) begin
				res.start_refused = 1'b1;
			end else begin
				out_shift_d  = {sdspi_pkg::CMD_PREFIX, item.cmd_index, item.cmd_arg, crc};
				kind_d       = item.resp_kind;
				hold_d       = item.hold_select;
				bit_count_d  = '0;
				in_shift_d   = '0;
				sel_d        = 1'b0;
				res.select_n = 1'b0;
				phase_d      = sdspi_pkg::PH_CMD;
			end
		end else begin
			unique case (phase_q)
				sdspi_pkg::PH_IDLE: begin
				end
				sdspi_pkg::PH_CMD: begin
					res.clock_pulse = 1'b1;
					res.mosi_bit    = out_shift_q[47];
					out_shift_d     = {out_shift_q[46:0], 1'b0};
					bit_count_d     = cnt_inc;
					if (cnt_inc >= sdspi_pkg::CNT_W'(sdspi_pkg::FRAME_BITS)) begin
						bit_count_d = '0;
						phase_d     = sdspi_pkg::PH_GAP1;
					end
				end
				sdspi_pkg::PH_GAP1: begin
					res.clock_pulse = 1'b1;
					bit_count_d     = cnt_inc;
					if (cnt_inc >= sdspi_pkg::CNT_W'(sdspi_pkg::GAP_CLOCKS)) begin
						bit_count_d = '0;
						in_shift_d  = '0;
						if (kind_q == sdspi_pkg::KIND_R1 || kind_q == sdspi_pkg::KIND_R1B) begin
							phase_d = sdspi_pkg::PH_R1;
						end else if (kind_q == sdspi_pkg::KIND_R2) begin
							phase_d = sdspi_pkg::PH_R2;
						end else begin
							// unknown kind: skip the read, report zero
							resp_held_d = '0;
							do_release  = 1'b1;
						end
					end
				end
				sdspi_pkg::PH_R2: begin
					res.clock_pulse = 1'b1;
					in_shift_d      = in_next;
					bit_count_d     = cnt_inc;
					if (cnt_inc >= sdspi_pkg::CNT_W'(16)) begin
						resp_held_d = in_next;
						do_release  = 1'b1;
					end
				end
				sdspi_pkg::PH_R1, sdspi_pkg::PH_BUSY: begin
					res.clock_pulse = 1'b1;
					in_shift_d      = in_next;
					bit_count_d     = cnt_inc;
					if (cnt_inc >= sdspi_pkg::CNT_W'(8)) begin
						bit_count_d = '0;
						in_shift_d  = '0;
						if (phase_q == sdspi_pkg::PH_R1) begin
							if (in_next[7:0] != sdspi_pkg::BYTE_IDLE) begin
								resp_held_d = {sdspi_pkg::R1_UPPER, in_next[7:0]};
								if (kind_q == sdspi_pkg::KIND_R1B)
									phase_d = sdspi_pkg::PH_BUSY;
								else
									do_release = 1'b1;
							end
						end else if (in_next[7:0] != sdspi_pkg::BYTE_ZERO) begin
							do_release = 1'b1;
						end
					end
				end
				sdspi_pkg::PH_GAP2: begin
					res.clock_pulse = 1'b1;
					bit_count_d     = cnt_inc;
					if (cnt_inc >= sdspi_pkg::CNT_W'(sdspi_pkg::GAP_CLOCKS)) begin
						bit_count_d  = '0;
						res.done_res = 1'b1;
						res.response = resp_held_q;
						phase_d      = sdspi_pkg::PH_IDLE;
					end
				end
				default: begin
					phase_d = sdspi_pkg::PH_IDLE;
				end
			endcase
		end

		if (do_release) begin
			if (!hold_q)
				sel_d = 1'b1;
			bit_count_d = '0;
			phase_d     = sdspi_pkg::PH_GAP2;
		end

		res.busy_res = (phase_d != sdspi_pkg::PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= sdspi_pkg::PH_IDLE;
			bit_count_q <= '0;
			out_shift_q <= '0;
			in_shift_q  <= '0;
			kind_q      <= '0;
			hold_q      <= 1'b0;
			sel_q       <= 1'b1;
			resp_held_q <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			bit_count_q <= bit_count_d;
			out_shift_q <= out_shift_d;
			in_shift_q  <= in_shift_d;
			kind_q      <= kind_d;
			hold_q      <= hold_d;
			sel_q       <= sel_d;
			resp_held_q <= resp_held_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sdspi_out_reg.sv -----
//------------------------------------------------------------------------------
// sdspi_out_reg
// Result register on the master side; frees itself as the item is taken.
//------------------------------------------------------------------------------
`default_nettype none

module sdspi_out_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire sdspi_pkg::result_t res_d,
	input  wire logic               take,
	output logic                    room,
	output logic                    valid,
	output sdspi_pkg::result_t      res_q
);

	logic valid_q;

	assign room  = !valid_q || take;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_d;
	end

endmodule

`default_nettype wire
